>>> hdl/rwts_pkg.sv
// shared types and constants for the raycast wall texel shader
package rwts_pkg;

   localparam int LH_W    = 12;   // line height width
   localparam int D_W     = 22;   // signed texture row numerator width
   localparam int FRAC_W  = 30;   // hit fraction width, Q0.30
   localparam int COORD_W = 8;    // texture coordinate width, covers up to 256 texels
   localparam int DIV_LSB = 8;    // texture row carries 8 fraction bits before the final floor

   localparam logic [23:0] SHADE_MASK = 24'h7F7F7F;
   localparam logic [23:0] GRID_RED   = 24'hC00000;

   localparam logic [1:0] CELL_NONE  = 2'd0;
   localparam logic [1:0] CELL_GRID  = 2'd1;
   localparam logic [1:0] CELL_GREEN = 2'd2;
   localparam logic [1:0] CELL_GREY  = 2'd3;

   typedef struct packed {
      logic               hit_side;
      logic [21:0]        origin_x;
      logic [21:0]        origin_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [23:0]        perp_distance;
      logic [1:0]         wall_cell;
      logic [11:0]        line_height;
      logic [9:0]         pixel_row;
      logic [10:0]        pixel_col;
   } req_type;

   typedef struct packed {
      logic [23:0] rgb;
      logic [9:0]  out_row;
      logic [10:0] out_col;
   } rsp_type;

   // per pixel attributes that travel down the pipeline
   typedef struct packed {
      logic               hit_side;
      logic [1:0]         wall_cell;
      logic               row_sat;
      logic [COORD_W-1:0] tex_x;
      logic [9:0]         row;
      logic [10:0]        col;
   } pix_type;

endpackage

>>> hdl/rwts_front.sv
// front stages: wall hit fraction, texture column, texture row numerator
module rwts_front #(
   parameter int TEXTURE_WIDTH  = 64,
   parameter int TEXTURE_HEIGHT = 64,
   parameter int SCREEN_HEIGHT  = 480,
   parameter int REM_W          = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  rwts_pkg::req_type in_req,
   output logic              out_valid,
   output rwts_pkg::pix_type out_pix,
   output logic [REM_W-1:0]  out_rem,
   output logic [rwts_pkg::LH_W-1:0] out_lh
);
   import rwts_pkg::*;

   // stage 1
   logic [21:0]        base;
   logic signed [15:0] dir;
   logic signed [24:0] dist_s;
   logic signed [40:0] prod;
   logic [LH_W-1:0]    lh_fix;

   logic              s1_valid_ff;
   logic [FRAC_W-1:0] s1_base_ff,   s1_base_in;
   logic [FRAC_W-1:0] s1_prod_ff,   s1_prod_in;
   logic [D_W-1:0]    s1_d_ff,      s1_d_in;
   logic              s1_mirror_ff, s1_mirror_in;
   logic [LH_W-1:0]   s1_lh_ff;
   pix_type           s1_pix_ff,    s1_pix_in;

   always_comb begin
      base   = in_req.hit_side ? in_req.origin_x : in_req.origin_y;
      dir    = in_req.hit_side ? in_req.dir_x : in_req.dir_y;
      dist_s = {1'b0, in_req.perp_distance};
      prod   = dist_s * dir;
      lh_fix = (in_req.line_height == '0) ? LH_W'(1) : in_req.line_height;
      s1_base_in = {base[15:0], 14'b0};
      s1_prod_in = prod[FRAC_W-1:0];
      // modulo 2^D_W, bit D_W-1 is the sign
      s1_d_in = D_W'({in_req.pixel_row, 8'b0}) + D_W'({lh_fix, 7'b0})
              - D_W'(SCREEN_HEIGHT * 128);
      s1_mirror_in = (!in_req.hit_side && !in_req.dir_x[15] && (in_req.dir_x != '0))
                   || (in_req.hit_side && in_req.dir_y[15]);
      s1_pix_in.hit_side  = in_req.hit_side;
      s1_pix_in.wall_cell = in_req.wall_cell;
      s1_pix_in.row_sat   = 1'b0;
      s1_pix_in.tex_x     = '0;
      s1_pix_in.row       = in_req.pixel_row;
      s1_pix_in.col       = in_req.pixel_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_base_ff   <= s1_base_in;
         s1_prod_ff   <= s1_prod_in;
         s1_d_ff      <= s1_d_in;
         s1_mirror_ff <= s1_mirror_in;
         s1_lh_ff     <= lh_fix;
         s1_pix_ff    <= s1_pix_in;
      end
   end

   // stage 2
   logic              s2_valid_ff;
   logic [FRAC_W-1:0] s2_frac_ff, s2_frac_in;
   logic [19:0]       s2_d_ff,    s2_d_in;
   logic              s2_mirror_ff;
   logic [LH_W-1:0]   s2_lh_ff;
   pix_type           s2_pix_ff,  s2_pix_in;
   logic              d_neg;

   always_comb begin
      s2_frac_in = s1_base_ff + s1_prod_ff;
      d_neg      = s1_d_ff[D_W-1];
      s2_pix_in  = s1_pix_ff;
      // row past the bottom of the texture whenever d >= 256 * line height
      s2_pix_in.row_sat = !d_neg
                        && (s1_d_ff[D_W-2:0] >= (D_W-1)'({s1_lh_ff, 8'b0}));
      // above the texture: zero numerator gives texture row 0
      s2_d_in = d_neg ? '0 : s1_d_ff[19:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_frac_ff   <= s2_frac_in;
         s2_d_ff      <= s2_d_in;
         s2_mirror_ff <= s1_mirror_ff;
         s2_lh_ff     <= s1_lh_ff;
         s2_pix_ff    <= s2_pix_in;
      end
   end

   // stage 3
   logic [FRAC_W+8:0]  tx_prod;
   logic [COORD_W-1:0] tx_raw;
   logic               s3_valid_ff;
   pix_type            s3_pix_ff, s3_pix_in;
   logic [REM_W-1:0]   s3_rem_ff, s3_rem_in;
   logic [LH_W-1:0]    s3_lh_ff;

   always_comb begin
      tx_prod = (FRAC_W+9)'(s2_frac_ff) * (FRAC_W+9)'(TEXTURE_WIDTH);
      tx_raw  = tx_prod[FRAC_W+COORD_W-1:FRAC_W];
      s3_pix_in = s2_pix_ff;
      s3_pix_in.tex_x = s2_mirror_ff ? (COORD_W'(TEXTURE_WIDTH - 1) - tx_raw) : tx_raw;
      s3_rem_in = REM_W'(s2_d_ff) * REM_W'(TEXTURE_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_pix_ff <= s3_pix_in;
         s3_rem_ff <= s3_rem_in;
         s3_lh_ff  <= s2_lh_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_pix   = s3_pix_ff;
   assign out_rem   = s3_rem_ff;
   assign out_lh    = s3_lh_ff;

endmodule

>>> hdl/rwts_div_stage.sv
// one restoring division stage of the texture row divider, one quotient bit
module rwts_div_stage #(
   parameter int REM_W   = 26,
   parameter int BIT_POS = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  rwts_pkg::pix_type            in_pix,
   input  logic [REM_W-1:0]             in_rem,
   input  logic [rwts_pkg::LH_W-1:0]    in_lh,
   input  logic [rwts_pkg::COORD_W-1:0] in_quo,
   output logic                         out_valid,
   output rwts_pkg::pix_type            out_pix,
   output logic [REM_W-1:0]             out_rem,
   output logic [rwts_pkg::LH_W-1:0]    out_lh,
   output logic [rwts_pkg::COORD_W-1:0] out_quo
);
   import rwts_pkg::*;

   logic [REM_W-1:0]   dvs;
   logic               fits;
   logic               valid_ff;
   pix_type            pix_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [LH_W-1:0]    lh_ff;
   logic [COORD_W-1:0] quo_ff, quo_in;

   always_comb begin
      // divisor is line height * 256, aligned to this quotient bit
      dvs    = REM_W'({in_lh, DIV_LSB'(0)}) << BIT_POS;
      fits   = (in_rem >= dvs);
      rem_in = fits ? (in_rem - dvs) : in_rem;
      quo_in = in_quo;
      quo_in[BIT_POS] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_ff <= in_pix;
         rem_ff <= rem_in;
         lh_ff  <= in_lh;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;
   assign out_rem   = rem_ff;
   assign out_lh    = lh_ff;
   assign out_quo   = quo_ff;

endmodule

>>> hdl/rwts_texel.sv
// procedural texture lookup, side shading and result register
module rwts_texel #(
   parameter int TEXTURE_WIDTH  = 64,
   parameter int TEXTURE_HEIGHT = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  rwts_pkg::pix_type            in_pix,
   input  logic [rwts_pkg::COORD_W-1:0] in_quo,
   output logic                         out_valid,
   output rwts_pkg::rsp_type            out_rsp
);
   import rwts_pkg::*;

   localparam int TXI_W = $clog2(TEXTURE_WIDTH);
   localparam int TYI_W = $clog2(TEXTURE_HEIGHT);

   logic [7:0] xs_tab [TEXTURE_WIDTH];
   logic [7:0] ys_tab [TEXTURE_HEIGHT];

   // coordinate scaled to 0..255, worked out per entry at elaboration
   for (genvar gi = 0; gi < TEXTURE_WIDTH; gi++) begin : g_xs
      assign xs_tab[gi] = 8'((gi * 256) / TEXTURE_WIDTH);
   end
   for (genvar gj = 0; gj < TEXTURE_HEIGHT; gj++) begin : g_ys
      assign ys_tab[gj] = 8'((gj * 256) / TEXTURE_HEIGHT);
   end

   logic [COORD_W-1:0] tx;
   logic [COORD_W-1:0] ty;
   logic [7:0]         xr;
   logic [23:0]        color;
   logic               valid_ff;
   rsp_type            rsp_ff, rsp_in;

   always_comb begin
      tx = in_pix.tex_x;
      ty = in_pix.row_sat ? COORD_W'(TEXTURE_HEIGHT - 1) : in_quo;
      xr = xs_tab[tx[TXI_W-1:0]] ^ ys_tab[ty[TYI_W-1:0]];
      unique case (in_pix.wall_cell)
         CELL_GRID: begin
            color = ((tx[3:0] != '0) && (ty[3:0] != '0)) ? GRID_RED : '0;
         end
         CELL_GREEN: begin
            color = {8'h00, xr, 8'h00};
         end
         CELL_GREY: begin
            color = {xr, xr, xr};
         end
         CELL_NONE: begin
            color = '0;
         end
         default: begin
            color = '0;
         end
      endcase
      rsp_in.rgb     = in_pix.hit_side ? ({1'b0, color[23:1]} & SHADE_MASK) : color;
      rsp_in.out_row = in_pix.row;
      rsp_in.out_col = in_pix.col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> hdl/raycast_wall_texel_shader.sv
// Wall texel shader for a raycaster: one wall pixel in, its RGB colour out.
// The block accepts one pixel per clock and keeps that rate for as long as the
// result side keeps taking transactions. Three front stages form the wall hit
// fraction, the mirrored texture column and the texture row numerator, a
// restoring divider by the slice height resolves one texture row bit per
// stage, and a last stage reads the procedural texture, shades y-side hits and
// holds the result. A stall on the result side freezes the whole pipeline in
// place, so no transaction is lost or repeated.
module raycast_wall_texel_shader #(
   parameter int TEXTURE_WIDTH  = 64,
   parameter int TEXTURE_HEIGHT = 64,
   parameter int SCREEN_HEIGHT  = 480
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rwts_pkg::rsp_type rsp_data
);
   import rwts_pkg::*;

   localparam int QB    = $clog2(TEXTURE_HEIGHT);
   localparam int REM_W = QB + LH_W + DIV_LSB;

   logic               advance;
   logic [QB:0]        stage_valid;
   pix_type            stage_pix [QB+1];
   logic [REM_W-1:0]   stage_rem [QB+1];
   logic [LH_W-1:0]    stage_lh  [QB+1];
   logic [COORD_W-1:0] stage_quo [QB+1];

   // whole pipeline moves together unless the result register is held
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   rwts_front #(
      .TEXTURE_WIDTH (TEXTURE_WIDTH),
      .TEXTURE_HEIGHT(TEXTURE_HEIGHT),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .REM_W         (REM_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_req   (req_data),
      .out_valid(stage_valid[0]),
      .out_pix  (stage_pix[0]),
      .out_rem  (stage_rem[0]),
      .out_lh   (stage_lh[0])
   );

   assign stage_quo[0] = '0;

   for (genvar g = 0; g < QB; g++) begin : g_div
      rwts_div_stage #(
         .REM_W  (REM_W),
         .BIT_POS(QB - 1 - g)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (stage_valid[g]),
         .in_pix   (stage_pix[g]),
         .in_rem   (stage_rem[g]),
         .in_lh    (stage_lh[g]),
         .in_quo   (stage_quo[g]),
         .out_valid(stage_valid[g+1]),
         .out_pix  (stage_pix[g+1]),
         .out_rem  (stage_rem[g+1]),
         .out_lh   (stage_lh[g+1]),
         .out_quo  (stage_quo[g+1])
      );
   end

   rwts_texel #(
      .TEXTURE_WIDTH (TEXTURE_WIDTH),
      .TEXTURE_HEIGHT(TEXTURE_HEIGHT)
   ) u_texel (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (stage_valid[QB]),
      .in_pix   (stage_pix[QB]),
      .in_quo   (stage_quo[QB]),
      .out_valid(rsp_valid),
      .out_rsp  (rsp_data)
   );

   // an empty result register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while result register empty");

   // during a stall every stage holds its transaction
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(stage_valid))
      else $error("pipeline moved during a stall");

   // an unsaturated texture row always lands inside the texture
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      stage_valid[QB] && !stage_pix[QB].row_sat
         |-> ({1'b0, stage_quo[QB]} < (COORD_W+1)'(TEXTURE_HEIGHT)))
      else $error("texture row quotient out of range");

endmodule

>>> verif/tb.sv
// testbench for raycast_wall_texel_shader: directed and random wall pixels vs a predictor
module tb;
   import rwts_pkg::*;

   localparam int TEX_W = 64;
   localparam int TEX_H = 64;
   localparam int SCR_H = 480;
   localparam int RANDOM_ITEMS = 1200;
   localparam int QUIET_ITEMS  = 150;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_pixels[$];
   rsp_type expected_pixels[$];
   int      error_count = 0;
   int      send_gap = 0;
   int      stall_gap = 0;
   bit      quiet = 1'b0;

   raycast_wall_texel_shader i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // colour of one wall pixel as the block should produce it
   function automatic rsp_type shade_texel(input req_type px);
      rsp_type           res;
      logic [21:0]       base;
      longint            dir_v;
      longint            hit;
      longint unsigned   frac;
      longint            d;
      longint            q;
      int                tx;
      int                ty;
      int                lh;
      logic [7:0]        xr;
      logic [23:0]       color;
      base  = px.hit_side ? px.origin_x : px.origin_y;
      dir_v = px.hit_side ? longint'($signed(px.dir_x)) : longint'($signed(px.dir_y));
      hit   = (longint'(base) <<< 14) + longint'(px.perp_distance) * dir_v;
      frac  = longint'(hit) & 64'h3FFF_FFFF;
      tx    = int'((frac * TEX_W) >> 30);
      if ((!px.hit_side && $signed(px.dir_x) > 0) || (px.hit_side && $signed(px.dir_y) < 0))
         tx = TEX_W - 1 - tx;
      lh = (px.line_height == '0) ? 1 : int'(px.line_height);
      d  = longint'(px.pixel_row) * 256 - longint'(SCR_H) * 128 + longint'(lh) * 128;
      if (d < 0) begin
         ty = 0;
      end else begin
         q  = (d * TEX_H / lh) >>> 8;
         ty = (q > TEX_H - 1) ? TEX_H - 1 : int'(q);
      end
      xr = 8'((((tx * 256) / TEX_W) ^ ((ty * 256) / TEX_H)) & 255);
      case (px.wall_cell)
         CELL_GRID:  color = ((tx % 16) != 0 && (ty % 16) != 0) ? GRID_RED : 24'h0;
         CELL_GREEN: color = {8'h00, xr, 8'h00};
         CELL_GREY:  color = {xr, xr, xr};
         default:    color = 24'h0;
      endcase
      if (px.hit_side)
         color = (color >> 1) & SHADE_MASK;
      res.rgb     = color;
      res.out_row = px.pixel_row;
      res.out_col = px.pixel_col;
      return res;
   endfunction

   function automatic req_type make_pixel(input logic side, input logic [21:0] ox,
                                          input logic [21:0] oy, input logic [15:0] dx,
                                          input logic [15:0] dy, input logic [23:0] hit_dist,
                                          input logic [1:0] wall_sel, input logic [11:0] lh,
                                          input logic [9:0] row, input logic [10:0] col);
      req_type px;
      px.hit_side      = side;
      px.origin_x      = ox;
      px.origin_y      = oy;
      px.dir_x         = dx;
      px.dir_y         = dy;
      px.perp_distance = hit_dist;
      px.wall_cell     = wall_sel;
      px.line_height   = lh;
      px.pixel_row     = row;
      px.pixel_col     = col;
      return px;
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      int      lo;
      int      hi;
      px.hit_side      = 1'($urandom_range(0, 1));
      px.origin_x      = 22'($urandom());
      px.origin_y      = 22'($urandom());
      px.dir_x         = 16'($urandom());
      px.dir_y         = 16'($urandom());
      px.perp_distance = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 1 << 18))
                                                    : 24'($urandom());
      px.wall_cell     = ($urandom_range(0, 3) == 0) ? 2'($urandom())
                                                    : 2'($urandom_range(1, 3));
      px.pixel_col     = 11'($urandom());
      if ($urandom_range(0, 9) < 7) begin
         // row across the projected slice, reaching two rows past its top and bottom edge
         px.line_height = 12'($urandom_range(1, 700));
         lo = (SCR_H - int'(px.line_height)) / 2 - 2;
         hi = (SCR_H + int'(px.line_height)) / 2 + 2;
         if (lo < 0)
            lo = 0;
         if (hi > 1023)
            hi = 1023;
         px.pixel_row = 10'($urandom_range(lo, hi));
      end else begin
         px.line_height = 12'($urandom());
         px.pixel_row   = 10'($urandom());
      end
      return px;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
         send_gap  <= 0;
         stall_gap <= 0;
      end else begin
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_data  <= pending_pixels.pop_front();
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 15) == 0)
                  send_gap <= $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_gap != 0) begin
            stall_gap <= stall_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 15) == 0)
               stall_gap <= $urandom_range(1, 12);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && req_ready)
         expected_pixels.push_back(shade_texel(req_data));
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected transaction rgb=%06h row=%0d col=%0d", $time,
                     rsp_data.rgb, rsp_data.out_row, rsp_data.out_col);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.rgb !== want.rgb) begin
               $display("%0t: rgb mismatch expected %06h actual %06h", $time,
                        want.rgb, rsp_data.rgb);
               error_count++;
            end
            if (rsp_data.out_row !== want.out_row) begin
               $display("%0t: out_row mismatch expected %0d actual %0d", $time,
                        want.out_row, rsp_data.out_row);
               error_count++;
            end
            if (rsp_data.out_col !== want.out_col) begin
               $display("%0t: out_col mismatch expected %0d actual %0d", $time,
                        want.out_col, rsp_data.out_col);
               error_count++;
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("raycast_wall_texel_shader verification failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero line height and no wall cell, then extreme field values
      pending_pixels.push_back(make_pixel(1'b0, 22'h000000, 22'h000000, 16'h0000, 16'h0000,
                                          24'h000000, CELL_NONE, 12'd0, 10'd0, 11'd0));
      pending_pixels.push_back(make_pixel(1'b1, 22'h3FFFFF, 22'h3FFFFF, 16'h7FFF, 16'h7FFF,
                                          24'hFFFFFF, CELL_GREY, 12'd4095, 10'd1023, 11'd2047));
      pending_pixels.push_back(make_pixel(1'b0, 22'h3FFFFF, 22'h3FFFFF, 16'h8000, 16'h8000,
                                          24'hFFFFFF, CELL_GREEN, 12'd4095, 10'd0, 11'd1));
      pending_pixels.push_back(make_pixel(1'b1, 22'h000000, 22'h000000, 16'h8000, 16'h8000,
                                          24'h000001, CELL_GRID, 12'd1, 10'd240, 11'd1024));
      // mirrored column on both sides
      pending_pixels.push_back(make_pixel(1'b0, 22'h012345, 22'h02A5C3, 16'h2000, 16'h1234,
                                          24'h018000, CELL_GREY, 12'd480, 10'd100, 11'd5));
      pending_pixels.push_back(make_pixel(1'b1, 22'h02A5C3, 22'h012345, 16'h1000, 16'hE000,
                                          24'h018000, CELL_GREEN, 12'd480, 10'd300, 11'd6));
      // row above and below the texture
      pending_pixels.push_back(make_pixel(1'b0, 22'h031000, 22'h018800, 16'hC000, 16'h3000,
                                          24'h020000, CELL_GREY, 12'd10, 10'd0, 11'd7));
      pending_pixels.push_back(make_pixel(1'b1, 22'h031000, 22'h018800, 16'hC000, 16'h3000,
                                          24'h020000, CELL_GREY, 12'd10, 10'd1023, 11'd8));
      // grid line at column zero, grid interior, all cells on both sides
      pending_pixels.push_back(make_pixel(1'b0, 22'h010000, 22'h020000, 16'hC000, 16'h4000,
                                          24'h000000, CELL_GRID, 12'd480, 10'd250, 11'd9));
      for (int s = 0; s < 2; s++) begin
         for (int c = CELL_GRID; c <= CELL_GREY; c++)
            pending_pixels.push_back(make_pixel(1'(s), 22'h0147AE, 22'h0251EB, 16'hF123,
                                                16'h0ABC, 24'h03C000, 2'(c), 12'd300,
                                                10'(200 + 20 * c), 11'(100 + c + 3 * s)));
      end
      pending_pixels.push_back(make_pixel(1'b0, 22'h155555, 22'h2AAAAA, 16'h5555, 16'hAAAA,
                                          24'h555555, CELL_GREEN, 12'hAAA, 10'h155, 11'h2AA));
      pending_pixels.push_back(make_pixel(1'b1, 22'h2AAAAA, 22'h155555, 16'hAAAA, 16'h5555,
                                          24'hAAAAAA, CELL_GREY, 12'h555, 10'h2AA, 11'h555));

      // hold the sender until the pipeline has fully drained
      while (pending_pixels.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);

      for (int i = 0; i < RANDOM_ITEMS; i++)
         pending_pixels.push_back(random_pixel());
      while (pending_pixels.size() != 0)
         @(posedge clock);

      quiet = 1'b1;
      for (int i = 0; i < QUIET_ITEMS; i++)
         pending_pixels.push_back(random_pixel());
      while (pending_pixels.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("raycast_wall_texel_shader verification clean");
      end else begin
         $display("raycast_wall_texel_shader verification failed");
      end
      $finish;
   end

endmodule

>>> raycast_wall_texel_shader.f
hdl/rwts_pkg.sv
hdl/rwts_front.sv
hdl/rwts_div_stage.sv
hdl/rwts_texel.sv
hdl/raycast_wall_texel_shader.sv
verif/tb.sv
